// File: rtl/fpdl_pkg.sv
// Shared types and constants for the fixed-point dense layer.
package fpdl_pkg;

    // Index fields in the command word cover both size parameters up to 64.
    localparam int IDX_W = 6;
    localparam int DATA_W = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_LENGTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LENGTH = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_ENABLE   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRACTION_BITS = 8'd3;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_LOAD_WEIGHT = 2'd0,
        OP_LOAD_BIAS   = 2'd1,
        OP_DATA        = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CMD_WEIGHT = 2'd0,
        CMD_BIAS   = 2'd1,
        CMD_DATA   = 2'd2
    } cmd_kind_t;

    // Classified request handed from the front end to the back end.
    // For data requests, row holds the element position within the row.
    typedef struct packed {
        cmd_kind_t          kind;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   feat;
        logic [DATA_W-1:0]  value;
        logic               final_row;
        logic               first;
        logic               row_end;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0]  result;
        logic [3:0]         feature_index;
        logic               last_of_row;
        logic               sequence_end;
    } res_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MAC,
        BK_DRAIN,
        BK_EMIT_RD,
        BK_EMIT_PUSH
    } bk_state_t;

endpackage

// File: rtl/fixed_point_dense_layer.sv
// Top level of the fixed-point dense layer: config registers and channel wiring.
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------------
//  request   | push / full        | op, weight_row, feature_sel, value, final_row
//  result    | empty / pop        | result, feature_index, last_of_row,
//            |                    | sequence_end
//  config    | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Flow: a load request is written to its store directly from idle. For a data
// request, one shared multiply-accumulate walks all OUT_MAX accumulators
// through a 3-stage read/multiply/write pipeline that drains before the next
// request. The last element of a row then emits each feature by an accumulator
// and bias memory read, then a result push.
// Reset clears control state and config registers only; stores need no
// clearing, since the first element of each row overwrites the accumulators.
// A 2-entry request queue lets the front accept while the back works; a full
// result queue stalls emission without losing state.
module fixed_point_dense_layer #(
    parameter int IN_MAX = 16,
    parameter int OUT_MAX = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // request side
    input  logic                                 push,
    output logic                                 full,
    input  logic [1:0]                           op,
    input  logic [3:0]                           weight_row,
    input  logic [3:0]                           feature_sel,
    input  logic signed [fpdl_pkg::DATA_W-1:0]   value,
    input  logic                                 final_row,
    // result side
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [fpdl_pkg::DATA_W-1:0]   result,
    output logic [3:0]                           feature_index,
    output logic                                 last_of_row,
    output logic                                 sequence_end,
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fpdl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fpdl_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int IL_W = ($clog2(IN_MAX + 1) > 5) ? $clog2(IN_MAX + 1) : 5;
    localparam int OL_W = ($clog2(OUT_MAX + 1) > 5) ? $clog2(OUT_MAX + 1) : 5;

    // config registers
    logic [4:0] input_length_reg, input_length_next;
    logic [4:0] output_length_reg, output_length_next;
    logic       bias_enable_reg, bias_enable_next;
    logic [4:0] fraction_bits_reg, fraction_bits_next;

    logic [IL_W-1:0] ilen;
    logic [OL_W-1:0] olen;

    fpdl_pkg::cmd_t cmd_in, cmd_out;
    logic           cmd_push, cmd_full, cmd_pop, cmd_empty;
    fpdl_pkg::res_t res_in, res_out;
    logic           res_push, res_full;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        input_length_next  = input_length_reg;
        output_length_next = output_length_reg;
        bias_enable_next   = bias_enable_reg;
        fraction_bits_next = fraction_bits_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                fpdl_pkg::CFG_INPUT_LENGTH:  input_length_next  = cfg_data[4:0];
                fpdl_pkg::CFG_OUTPUT_LENGTH: output_length_next = cfg_data[4:0];
                fpdl_pkg::CFG_BIAS_ENABLE:   bias_enable_next   = cfg_data[0];
                fpdl_pkg::CFG_FRACTION_BITS: fraction_bits_next = cfg_data[4:0];
                default:                     input_length_next  = input_length_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_length_reg  <= 5'd16;
            output_length_reg <= 5'd16;
            bias_enable_reg   <= 1'b1;
            fraction_bits_reg <= 5'd12;
        end
        else
        begin
            input_length_reg  <= input_length_next;
            output_length_reg <= output_length_next;
            bias_enable_reg   <= bias_enable_next;
            fraction_bits_reg <= fraction_bits_next;
        end
    end

    // lengths: zero acts as one, anything above the store size saturates
    always_comb
    begin
        if (input_length_reg == 5'd0)
        begin
            ilen = IL_W'(1);
        end
        else if (IL_W'(input_length_reg) > IL_W'(IN_MAX))
        begin
            ilen = IL_W'(IN_MAX);
        end
        else
        begin
            ilen = IL_W'(input_length_reg);
        end

        if (output_length_reg == 5'd0)
        begin
            olen = OL_W'(1);
        end
        else if (OL_W'(output_length_reg) > OL_W'(OUT_MAX))
        begin
            olen = OL_W'(OUT_MAX);
        end
        else
        begin
            olen = OL_W'(output_length_reg);
        end
    end

    fpdl_front #(
        .IN_MAX  (IN_MAX),
        .OUT_MAX (OUT_MAX)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .op          (op),
        .weight_row  (weight_row),
        .feature_sel (feature_sel),
        .value       (value),
        .final_row   (final_row),
        .ilen        (ilen),
        .q_full      (cmd_full),
        .q_push      (cmd_push),
        .q_cmd       (cmd_in)
    );

    assign full = cmd_full;

    fpdl_fifo #(
        .T     (fpdl_pkg::cmd_t),
        .DEPTH (2)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    fpdl_back #(
        .IN_MAX  (IN_MAX),
        .OUT_MAX (OUT_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .olen      (olen),
        .bias_en   (bias_enable_reg),
        .frac      (fraction_bits_reg),
        .out_full  (res_full),
        .out_push  (res_push),
        .out_item  (res_in)
    );

    fpdl_fifo #(
        .T     (fpdl_pkg::res_t),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign result        = res_out.result;
    assign feature_index = res_out.feature_index;
    assign last_of_row   = res_out.last_of_row;
    assign sequence_end  = res_out.sequence_end;

endmodule

// File: rtl/fpdl_fifo.sv
// Small register FIFO used between front and back and on the result side.
module fpdl_fifo #(
    parameter type T = logic,
    parameter int DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  T     wr_data,
    output logic full,
    input  logic rd_en,
    output T     rd_data,
    output logic empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T             mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/fpdl_front.sv
// Front end: accepts requests, drops invalid ones, tracks position in the row.
module fpdl_front #(
    parameter int IN_MAX = 16,
    parameter int OUT_MAX = 16,
    localparam int IL_W = ($clog2(IN_MAX + 1) > 5) ? $clog2(IN_MAX + 1) : 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [1:0]                    op,
    input  logic [3:0]                    weight_row,
    input  logic [3:0]                    feature_sel,
    input  logic [fpdl_pkg::DATA_W-1:0]   value,
    input  logic                          final_row,
    input  logic [IL_W-1:0]               ilen,
    input  logic                          q_full,
    output logic                          q_push,
    output fpdl_pkg::cmd_t                q_cmd
);

    localparam int CNT_W = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IL_W-1:0]  cnt_inc;
    logic             accept;
    logic             row_end;

    assign accept  = push && !q_full;
    assign cnt_inc = IL_W'(cnt_reg) + IL_W'(1);
    assign row_end = (cnt_inc >= ilen);

    always_comb
    begin
        q_push          = 1'b0;
        cnt_next        = cnt_reg;
        q_cmd.kind      = fpdl_pkg::CMD_DATA;
        q_cmd.row       = fpdl_pkg::IDX_W'(weight_row);
        q_cmd.feat      = fpdl_pkg::IDX_W'(feature_sel);
        q_cmd.value     = value;
        q_cmd.final_row = final_row;
        q_cmd.first     = (cnt_reg == '0);
        q_cmd.row_end   = row_end;
        case (op)
            fpdl_pkg::OP_LOAD_WEIGHT:
            begin
                q_cmd.kind = fpdl_pkg::CMD_WEIGHT;
                q_push = accept && ({28'd0, weight_row} < 32'(IN_MAX))
                                && ({28'd0, feature_sel} < 32'(OUT_MAX));
            end
            fpdl_pkg::OP_LOAD_BIAS:
            begin
                q_cmd.kind = fpdl_pkg::CMD_BIAS;
                q_push = accept && ({28'd0, feature_sel} < 32'(OUT_MAX));
            end
            fpdl_pkg::OP_DATA:
            begin
                q_cmd.kind = fpdl_pkg::CMD_DATA;
                q_cmd.row  = fpdl_pkg::IDX_W'(cnt_reg);
                q_push     = accept;
                if (accept)
                begin
                    cnt_next = row_end ? '0 : cnt_inc[CNT_W-1:0];
                end
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: rtl/fpdl_back.sv
// Back end: weight/bias stores, shared multiply-accumulate and result emission.
module fpdl_back #(
    parameter int IN_MAX = 16,
    parameter int OUT_MAX = 16,
    localparam int OL_W = ($clog2(OUT_MAX + 1) > 5) ? $clog2(OUT_MAX + 1) : 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  fpdl_pkg::cmd_t       cmd,
    output logic                 cmd_pop,
    input  logic [OL_W-1:0]      olen,
    input  logic                 bias_en,
    input  logic [4:0]           frac,
    input  logic                 out_full,
    output logic                 out_push,
    output fpdl_pkg::res_t       out_item
);

    localparam int CNT_W = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
    localparam int FW    = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
    localparam int WDEP  = IN_MAX * OUT_MAX;
    localparam int WA_W  = (WDEP > 1) ? $clog2(WDEP) : 1;

    fpdl_pkg::bk_state_t state_reg, state_next;
    fpdl_pkg::cmd_t      cur_reg, cur_next;
    logic [FW-1:0]       f_reg, f_next;

    // stores
    logic [fpdl_pkg::DATA_W-1:0] weight_mem [WDEP];
    logic [fpdl_pkg::DATA_W-1:0] bias_mem   [OUT_MAX];
    logic [fpdl_pkg::DATA_W-1:0] acc_mem    [OUT_MAX];
    logic [fpdl_pkg::DATA_W-1:0] w_rdata_reg, b_rdata_reg, a_rdata_reg;

    logic            w_we, b_we, w_re, b_re, a_re, issue;
    logic [WA_W-1:0] w_waddr, w_raddr;
    logic [FW-1:0]   cmd_feat;

    // MAC pipeline: stage 1 = read data back, stage 2 = accumulator write
    logic                        s1_v_reg, s2_v_reg;
    logic [FW-1:0]               s1_f_reg, s2_f_reg;
    logic [fpdl_pkg::DATA_W-1:0] s2_prod_reg, s2_acc_reg;

    logic                        last_feat;
    logic                        drained;
    logic [fpdl_pkg::DATA_W-1:0] shifted;

    assign cmd_feat  = cmd.feat[FW-1:0];
    assign w_waddr   = WA_W'(cmd.row[CNT_W-1:0]) * WA_W'(OUT_MAX) + WA_W'(cmd_feat);
    assign w_raddr   = WA_W'(cur_reg.row[CNT_W-1:0]) * WA_W'(OUT_MAX) + WA_W'(f_reg);
    assign last_feat = (OL_W'(f_reg) == olen - OL_W'(1));
    assign drained   = !s1_v_reg && !s2_v_reg;
    assign shifted   = $signed(a_rdata_reg) >>> frac;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fpdl_pkg::BK_IDLE:
            begin
                if (cmd_valid && cmd.kind == fpdl_pkg::CMD_DATA)
                begin
                    state_next = fpdl_pkg::BK_MAC;
                end
            end
            fpdl_pkg::BK_MAC:
            begin
                if (f_reg == FW'(OUT_MAX - 1))
                begin
                    state_next = fpdl_pkg::BK_DRAIN;
                end
            end
            fpdl_pkg::BK_DRAIN:
            begin
                if (drained)
                begin
                    state_next = cur_reg.row_end ? fpdl_pkg::BK_EMIT_RD : fpdl_pkg::BK_IDLE;
                end
            end
            fpdl_pkg::BK_EMIT_RD:
            begin
                state_next = fpdl_pkg::BK_EMIT_PUSH;
            end
            fpdl_pkg::BK_EMIT_PUSH:
            begin
                if (!out_full)
                begin
                    state_next = last_feat ? fpdl_pkg::BK_IDLE : fpdl_pkg::BK_EMIT_RD;
                end
            end
            default:
            begin
                state_next = fpdl_pkg::BK_IDLE;
            end
        endcase
    end

    // outputs and datapath controls
    always_comb
    begin
        cmd_pop  = 1'b0;
        w_we     = 1'b0;
        b_we     = 1'b0;
        w_re     = 1'b0;
        b_re     = 1'b0;
        a_re     = 1'b0;
        issue    = 1'b0;
        out_push = 1'b0;
        cur_next = cur_reg;
        f_next   = f_reg;
        case (state_reg)
            fpdl_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        fpdl_pkg::CMD_WEIGHT: w_we = 1'b1;
                        fpdl_pkg::CMD_BIAS:   b_we = 1'b1;
                        fpdl_pkg::CMD_DATA:
                        begin
                            cur_next = cmd;
                            f_next   = '0;
                        end
                        default: cmd_pop = 1'b1;
                    endcase
                end
            end
            fpdl_pkg::BK_MAC:
            begin
                w_re   = 1'b1;
                a_re   = 1'b1;
                issue  = 1'b1;
                f_next = (f_reg == FW'(OUT_MAX - 1)) ? '0 : f_reg + FW'(1);
            end
            fpdl_pkg::BK_DRAIN:
            begin
                f_next = '0;
            end
            fpdl_pkg::BK_EMIT_RD:
            begin
                a_re = 1'b1;
                b_re = 1'b1;
            end
            fpdl_pkg::BK_EMIT_PUSH:
            begin
                if (!out_full)
                begin
                    out_push = 1'b1;
                    f_next   = last_feat ? '0 : f_reg + FW'(1);
                end
            end
            default:
            begin
                f_next = '0;
            end
        endcase
    end

    always_comb
    begin
        out_item.result        = bias_en ? shifted + b_rdata_reg : shifted;
        out_item.feature_index = 4'(f_reg);
        out_item.last_of_row   = last_feat;
        out_item.sequence_end  = cur_reg.final_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpdl_pkg::BK_IDLE;
            f_reg     <= '0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            f_reg     <= f_next;
            s1_v_reg  <= issue;
            s2_v_reg  <= s1_v_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        s1_f_reg    <= f_reg;
        s2_f_reg    <= s1_f_reg;
        s2_prod_reg <= w_rdata_reg * cur_reg.value;
        s2_acc_reg  <= cur_reg.first ? '0 : a_rdata_reg;
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            weight_mem[w_waddr] <= cmd.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_re)
        begin
            w_rdata_reg <= weight_mem[w_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            bias_mem[cmd_feat] <= cmd.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_re)
        begin
            b_rdata_reg <= bias_mem[f_reg];
        end
    end

    // first element of a row overwrites, so no clearing pass is needed
    always_ff @(posedge clk)
    begin
        if (s2_v_reg)
        begin
            acc_mem[s2_f_reg] <= s2_acc_reg + s2_prod_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_re)
        begin
            a_rdata_reg <= acc_mem[f_reg];
        end
    end

endmodule
